// ===== hw/rtl/s3x_pkg.sv =====
`default_nettype none

package s3x_pkg;

  // Fixed field widths.
  localparam int PIX_W   = 32;
  localparam int COORD_W = 10;
  localparam int CFG_W   = 11;

  // Queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Register indexes, taken from paddr[2].
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Register reset values.
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd64;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd32;

  typedef logic [PIX_W-1:0] pix_t;

  // 3x3 neighborhood, indexed [row][column].
  typedef pix_t [2:0][2:0] win_t;

  // One queued item: the window after its update and the blocks it emits.
  typedef struct packed {
    win_t               win;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               emit1;
    logic               emit2;
  } qent_t;

  // One result item: the nine output pixels in raster order.
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    pix_t [8:0]         blk;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/s3x_queue.sv =====
`default_nettype none

module s3x_queue
  import s3x_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire qent_t             wdata,
  input  wire logic              pop,
  output qent_t                  rdata,
  output logic [QCNT_W-1:0]      count,
  output logic                   empty
);

  qent_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  assign rdata = entries[rd_ptr];
  assign empty = (count == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/s3x_front.sv =====
`default_nettype none

module s3x_front
  import s3x_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              req_type,
  input  wire logic [PIX_W-1:0]  pixel_in,
  input  wire logic [CFG_W-1:0]  image_width,
  input  wire logic [CFG_W-1:0]  image_height,
  input  wire logic [QCNT_W-1:0] q_count,
  output logic                   q_push,
  output qent_t                  q_entry
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  typedef struct packed {
    logic [CW-1:0]      x;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               x_zero;
    logic               emit1;
    logic               emit2;
    logic               drain;
    logic               y_ge2;
    pix_t               pix;
  } stage_t;

  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] w_m1;
  logic [RW-1:0] h_eff;
  logic [CW-1:0] x;
  logic [RW-1:0] y;
  logic          drain;
  logic          last_col;
  logic          keep;
  logic          accept;

  pix_t          cur_mem   [MAX_WIDTH];
  pix_t          above_mem [MAX_WIDTH];
  pix_t          cur_rd;
  pix_t          above_rd;

  logic          s1_valid;
  stage_t        s1;
  logic          byp;
  pix_t          byp_data;

  pix_t          mid;
  pix_t          above;
  pix_t          top;
  pix_t          bot;
  pix_t [2:0]    vcol;
  win_t          win;
  win_t          win_next;

  // Effective width and height: zero counts as one, anything above the maximum as the maximum.
  always_comb begin
    if (image_width == '0) begin
      w_m1 = '0;
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = CW'(32'(image_width) - 32'd1);
    end
    if (image_height == '0) begin
      h_eff = RW'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(image_height);
    end
  end

  // Classify the incoming item against the raster position.
  assign drain    = (32'(row_count) >= 32'(h_eff));
  assign x        = (col_count <= w_m1) ? col_count : w_m1;
  assign y        = drain ? h_eff : row_count;
  assign last_col = (x == w_m1);
  assign keep     = (req_type == drain);

  // Leave room in the queue for the item in flight and the new one.
  assign in_ready = (32'(q_count) + 32'(s1_valid)) < 32'(QDEPTH);
  assign accept   = in_valid && in_ready;

  // Raster position.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept && keep) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= drain ? '0 : RW'(32'(y) + 32'd1);
      end else begin
        col_count <= x + CW'(1);
        row_count <= y;
      end
    end
  end

  // Line store for the row just above: read old value, then take the new pixel.
  always_ff @(posedge clk) begin
    if (accept && keep) begin
      cur_rd <= cur_mem[x];
      if (!drain) begin
        cur_mem[x] <= pixel_in;
      end
    end
  end

  // Line store for the row two above: takes what the other store held, in the cycle after it is read.
  always_ff @(posedge clk) begin
    if (accept && keep) begin
      above_rd <= above_mem[x];
    end
    if (s1_valid && !s1.drain) begin
      above_mem[s1.x] <= cur_rd;
    end
  end

  // Item in flight between the store read and the window update.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      s1.x      <= x;
      s1.col    <= COORD_W'(x);
      s1.row    <= COORD_W'(y - RW'(1));
      s1.x_zero <= (x == '0);
      s1.emit1  <= (y != '0) && (x != '0);
      s1.emit2  <= (y != '0) && last_col;
      s1.drain  <= drain;
      s1.y_ge2  <= (32'(y) >= 32'd2);
      s1.pix    <= pixel_in;
      // The store write of the item ahead lands at the same address in this same cycle.
      byp       <= s1_valid && !s1.drain && (s1.x == x);
      byp_data  <= cur_rd;
    end
  end

  // Column entering the window: clamped above on the first row, replayed below when draining.
  assign mid   = cur_rd;
  assign above = byp ? byp_data : above_rd;
  assign top   = s1.y_ge2 ? above : mid;
  assign bot   = s1.drain ? mid : s1.pix;

  assign vcol[0] = top;
  assign vcol[1] = mid;
  assign vcol[2] = bot;

  // Slide the window, or fill it with the left edge column at the start of a line.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (s1.x_zero) begin
        win_next[r][0] = vcol[r];
        win_next[r][1] = vcol[r];
        win_next[r][2] = vcol[r];
      end else begin
        win_next[r][0] = win[r][1];
        win_next[r][1] = win[r][2];
        win_next[r][2] = vcol[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_valid) begin
      win <= win_next;
    end
  end

  // Hand items that emit blocks to the back.
  assign q_push        = s1_valid && (s1.emit1 || s1.emit2);
  assign q_entry.win   = win_next;
  assign q_entry.col   = s1.col;
  assign q_entry.row   = s1.row;
  assign q_entry.emit1 = s1.emit1;
  assign q_entry.emit2 = s1.emit2;

endmodule

`default_nettype wire

// ===== hw/rtl/s3x_back.sv =====
`default_nettype none

module s3x_back
  import s3x_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_empty,
  input  wire qent_t  q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output res_t        res
);

  logic second;
  logic use_cc2;
  logic last;
  logic load;
  pix_t a, b, c, d, e, f, g, h, i;
  logic db, bf, dh, hf;
  res_t res_next;

  // The left block of an item goes first; the right edge block follows it.
  assign use_cc2 = second || !q_head.emit1;
  assign last    = use_cc2 || !q_head.emit2;
  assign load    = !q_empty && (!out_valid || out_ready);
  assign q_pop   = load && last;

  // Neighborhood of the selected center column; the right edge repeats itself.
  always_comb begin
    a = use_cc2 ? q_head.win[0][1] : q_head.win[0][0];
    b = use_cc2 ? q_head.win[0][2] : q_head.win[0][1];
    c = q_head.win[0][2];
    d = use_cc2 ? q_head.win[1][1] : q_head.win[1][0];
    e = use_cc2 ? q_head.win[1][2] : q_head.win[1][1];
    f = q_head.win[1][2];
    g = use_cc2 ? q_head.win[2][1] : q_head.win[2][0];
    h = use_cc2 ? q_head.win[2][2] : q_head.win[2][1];
    i = q_head.win[2][2];
  end

  // Edge rules.
  assign db = (d == b) && (b != f) && (d != h);
  assign bf = (b == f) && (b != d) && (f != h);
  assign dh = (d == h) && (d != b) && (h != f);
  assign hf = (h == f) && (d != h) && (b != f);

  always_comb begin
    res_next.col    = use_cc2 ? q_head.col : q_head.col - COORD_W'(1);
    res_next.row    = q_head.row;
    res_next.blk[0] = db ? d : e;
    res_next.blk[1] = ((db && (e != c)) || (bf && (e != a))) ? b : e;
    res_next.blk[2] = bf ? f : e;
    res_next.blk[3] = ((db && (e != g)) || (dh && (e != a))) ? d : e;
    res_next.blk[4] = e;
    res_next.blk[5] = ((bf && (e != i)) || (hf && (e != c))) ? f : e;
    res_next.blk[6] = dh ? d : e;
    res_next.blk[7] = ((dh && (e != i)) || (hf && (e != g))) ? h : e;
    res_next.blk[8] = hf ? f : e;
    res_next.last   = last;
  end

  // Output register and the block-select flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        second    <= !last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/scale3x_pixel_upscaler.sv =====
// Throughput: one item per cycle while in_ready is high; an item at the last column past the
//   first row yields two results (one at width one), which the output register presents one
//   after the other, absorbed by a four-entry queue. Path: line store read, window update,
//   queue, output register; an item can wait in the queue while the output stalls.
// Reset: synchronous; clears counters, window, queue and output valid. Line stores are
//   not cleared; registers return to width 64 and height 32.
`default_nettype none

module scale3x_pixel_upscaler
  import s3x_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               req_type,
  input  wire logic [PIX_W-1:0]   pixel_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [COORD_W-1:0]      out_col,
  output logic [COORD_W-1:0]      out_row,
  output logic [PIX_W-1:0]        pix_top_left,
  output logic [PIX_W-1:0]        pix_top_mid,
  output logic [PIX_W-1:0]        pix_top_right,
  output logic [PIX_W-1:0]        pix_mid_left,
  output logic [PIX_W-1:0]        pix_centre,
  output logic [PIX_W-1:0]        pix_mid_right,
  output logic [PIX_W-1:0]        pix_bot_left,
  output logic [PIX_W-1:0]        pix_bot_mid,
  output logic [PIX_W-1:0]        pix_bot_right,
  output logic                    last_of_run
);

  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  image_height;
  logic              cfg_wr;
  logic              q_push;
  logic              q_pop;
  logic              q_empty;
  logic [QCNT_W-1:0] q_count;
  qent_t             q_wdata;
  qent_t             q_head;
  res_t              res;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  image_width  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: image_height <= pwdata[CFG_W-1:0];
        default:    image_width  <= image_width;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      default:    prdata = '0;
    endcase
  end

  // Front: raster position, line stores and window.
  s3x_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .pixel_in     (pixel_in),
    .image_width  (image_width),
    .image_height (image_height),
    .q_count      (q_count),
    .q_push       (q_push),
    .q_entry      (q_wdata)
  );

  // Queue between front and back.
  s3x_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_head),
    .count (q_count),
    .empty (q_empty)
  );

  // Back: edge rules and output register.
  s3x_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_col       = res.col;
  assign out_row       = res.row;
  assign pix_top_left  = res.blk[0];
  assign pix_top_mid   = res.blk[1];
  assign pix_top_right = res.blk[2];
  assign pix_mid_left  = res.blk[3];
  assign pix_centre    = res.blk[4];
  assign pix_mid_right = res.blk[5];
  assign pix_bot_left  = res.blk[6];
  assign pix_bot_mid   = res.blk[7];
  assign pix_bot_right = res.blk[8];
  assign last_of_run   = res.last;

  // The front's credit check keeps the queue from overflowing.
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count < QCNT_W'(QDEPTH)) || q_pop)
    else $error("item pushed into a full queue");

  // The back only retires queued items.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from an empty queue");

  // The second block of an item follows right behind the first.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_of_run) |=> out_valid)
    else $error("second block of an item did not follow");

endmodule

`default_nettype wire
